// ===== rtl/pole_pkg.sv =====
// Shared constants, codes and types of the positional ordered list engine.
package pole_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    localparam int REQ_W  = 3;
    localparam int POS_W  = 8;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 3;
    localparam int FPOS_W = 5;
    localparam int CNT_W  = 5;

    localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_LAST = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SEARCH   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SHOW     = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SHOW_REV = 3'd6;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

    typedef logic [2:0] t_cell_op;

    localparam t_cell_op CELL_HOLD = 3'd0;
    localparam t_cell_op CELL_INS  = 3'd1;
    localparam t_cell_op CELL_DEL  = 3'd2;
    localparam t_cell_op CELL_ROTL = 3'd3;
    localparam t_cell_op CELL_ROTR = 3'd4;

    typedef struct packed {
        t_cell_op                op;
        logic [IDX_W-1:0]        k;
        logic [IDX_W-1:0]        last;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctrl;

endpackage

// ===== rtl/pole_req_if.sv =====
// Request channel: valid, ready and the request fields.
interface pole_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [pole_pkg::REQ_W-1:0]           req_type;
    logic [pole_pkg::POS_W-1:0]           position;
    logic signed [pole_pkg::VAL_W-1:0]    value;

    modport source (output valid, req_type, position, value, input ready);
    modport sink   (input valid, req_type, position, value, output ready);
endinterface

// ===== rtl/pole_rsp_if.sv =====
// Result channel: valid, ready and the result fields.
interface pole_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [pole_pkg::ST_W-1:0]            status;
    logic [pole_pkg::FPOS_W-1:0]          found_position;
    logic signed [pole_pkg::VAL_W-1:0]    element;
    logic [pole_pkg::CNT_W-1:0]           entry_count;
    logic                                 last_of_run;

    modport source (output valid, status, found_position, element, entry_count,
                    last_of_run, input ready);
    modport sink   (input valid, status, found_position, element, entry_count,
                    last_of_run, output ready);
endinterface

// ===== rtl/positional_ordered_list_engine_top.sv =====
// Top level of the positional ordered list engine: sequencer, output register, cell row.
//
//  channel  | dir | handshake     | fields
//  ---------+-----+---------------+---------------------------------------------
//  i_req    | in  | valid / ready | req_type, position, value
//  o_rsp    | out | valid / ready | status, found_position, element,
//           |     |               | entry_count, last_of_run
//
// Insert, append, delete and unused codes: accept, then execute.
// Search: accept, compare in every cell, then a priority pick of the first match.
// A read-out of N entries: accept, start, then one rotation per beat.
// Reset clears the sequencer, the occupancy and the output valid flag; cells hold no reset.
// A stalled result beat holds the sequencer; a new request is taken only while idle.
module positional_ordered_list_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pole_req_if.sink    i_req,
    pole_rsp_if.source  o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIND = 2'd2;
    localparam logic [1:0] S_READ = 2'd3;

    logic [1:0] r_state, n_state;
    logic [pole_pkg::OCC_W-1:0] r_occ, n_occ;
    logic [pole_pkg::OCC_W-1:0] r_cnt, n_cnt;
    logic [pole_pkg::CAPACITY-1:0] r_match, n_match;

    logic [pole_pkg::REQ_W-1:0]        r_req_type;
    logic [pole_pkg::POS_W-1:0]        r_pos;
    logic signed [pole_pkg::VAL_W-1:0] r_value;

    logic                                r_ov;
    logic [pole_pkg::ST_W-1:0]           r_status;
    logic [pole_pkg::FPOS_W-1:0]         r_fpos;
    logic signed [pole_pkg::VAL_W-1:0]   r_elem;
    logic [pole_pkg::CNT_W-1:0]          r_count;
    logic                                r_last;

    logic                                ld;
    logic [pole_pkg::ST_W-1:0]           ld_status;
    logic [pole_pkg::FPOS_W-1:0]         ld_fpos;
    logic signed [pole_pkg::VAL_W-1:0]   ld_elem;
    logic                                ld_last;

    logic accept, slot_free;
    logic [8:0] pos9, occ9;
    logic [pole_pkg::IDX_W-1:0] last_idx;
    logic [pole_pkg::CAPACITY-1:0] in_use;
    logic [pole_pkg::CAPACITY-1:0] c_match;
    logic [pole_pkg::FPOS_W-1:0] first_pos;
    logic signed [pole_pkg::VAL_W-1:0] c_data [pole_pkg::CAPACITY];
    logic signed [pole_pkg::VAL_W-1:0] head, tail;
    pole_pkg::t_cell_ctrl cell_ctrl;

    assign accept    = i_req.valid && i_req.ready;
    assign slot_free = !r_ov || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign pos9     = {1'b0, r_pos};
    assign occ9     = 9'(r_occ);
    assign last_idx = pole_pkg::IDX_W'(r_occ - 1'b1);
    assign head     = c_data[0];
    assign tail     = c_data[last_idx];

    always_comb begin
        for (int i = 0; i < pole_pkg::CAPACITY; i++) begin
            in_use[i] = (i < int'(r_occ));
        end
    end

    always_comb begin
        first_pos = '0;
        for (int i = pole_pkg::CAPACITY - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                first_pos = pole_pkg::FPOS_W'(i + 1);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_occ     = r_occ;
        n_cnt     = r_cnt;
        n_match   = r_match;
        ld        = 1'b0;
        ld_status = pole_pkg::ST_OK;
        ld_fpos   = '0;
        ld_elem   = '0;
        ld_last   = 1'b1;
        cell_ctrl.op    = pole_pkg::CELL_HOLD;
        cell_ctrl.k     = '0;
        cell_ctrl.last  = last_idx;
        cell_ctrl.value = r_value;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                    ld      = 1'b1;
                    unique case (r_req_type)
                        pole_pkg::REQ_INSERT: begin
                            if (pos9 < 9'd1 || pos9 > occ9 + 9'd1) begin
                                ld_status = pole_pkg::ST_BADPOS;
                            end else if (int'(r_occ) >= pole_pkg::CAPACITY) begin
                                ld_status = pole_pkg::ST_FULL;
                            end else begin
                                cell_ctrl.op = pole_pkg::CELL_INS;
                                cell_ctrl.k  = pole_pkg::IDX_W'(r_pos - 8'd1);
                                n_occ        = r_occ + 1'b1;
                            end
                        end
                        pole_pkg::REQ_APPEND: begin
                            if (int'(r_occ) >= pole_pkg::CAPACITY) begin
                                ld_status = pole_pkg::ST_FULL;
                            end else begin
                                cell_ctrl.op = pole_pkg::CELL_INS;
                                cell_ctrl.k  = pole_pkg::IDX_W'(r_occ);
                                n_occ        = r_occ + 1'b1;
                            end
                        end
                        pole_pkg::REQ_DELETE: begin
                            if (r_occ == '0) begin
                                ld_status = pole_pkg::ST_EMPTY;
                            end else if (pos9 < 9'd1 || pos9 > occ9) begin
                                ld_status = pole_pkg::ST_BADPOS;
                            end else begin
                                cell_ctrl.op = pole_pkg::CELL_DEL;
                                cell_ctrl.k  = pole_pkg::IDX_W'(r_pos - 8'd1);
                                n_occ        = r_occ - 1'b1;
                            end
                        end
                        pole_pkg::REQ_DEL_LAST: begin
                            if (r_occ == '0) begin
                                ld_status = pole_pkg::ST_EMPTY;
                            end else begin
                                cell_ctrl.op = pole_pkg::CELL_DEL;
                                cell_ctrl.k  = last_idx;
                                n_occ        = r_occ - 1'b1;
                            end
                        end
                        pole_pkg::REQ_SEARCH: begin
                            if (r_occ == '0) begin
                                ld_status = pole_pkg::ST_EMPTY;
                            end else begin
                                // latch the compare flags, pick the first one in S_FIND
                                ld      = 1'b0;
                                n_match = c_match & in_use;
                                n_state = S_FIND;
                            end
                        end
                        pole_pkg::REQ_SHOW, pole_pkg::REQ_SHOW_REV: begin
                            if (r_occ == '0) begin
                                ld_status = pole_pkg::ST_EMPTY;
                            end else begin
                                ld      = 1'b0;
                                n_cnt   = '0;
                                n_state = S_READ;
                            end
                        end
                        default: ld_status = pole_pkg::ST_OK;
                    endcase
                end
            end
            S_FIND: begin
                if (slot_free) begin
                    ld        = 1'b1;
                    ld_fpos   = first_pos;
                    ld_status = (r_match != '0) ? pole_pkg::ST_OK : pole_pkg::ST_NOTFOUND;
                    n_state   = S_IDLE;
                end
            end
            S_READ: begin
                if (slot_free) begin
                    // emit one entry per beat and rotate it away; N rotations restore order
                    ld      = 1'b1;
                    ld_last = (r_cnt == r_occ - 1'b1);
                    n_cnt   = r_cnt + 1'b1;
                    if (r_req_type == pole_pkg::REQ_SHOW) begin
                        ld_elem      = head;
                        cell_ctrl.op = pole_pkg::CELL_ROTL;
                    end else begin
                        ld_elem      = tail;
                        cell_ctrl.op = pole_pkg::CELL_ROTR;
                    end
                    if (ld_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (ld) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_match <= n_match;
        if (accept) begin
            r_req_type <= i_req.req_type;
            r_pos      <= i_req.position;
            r_value    <= i_req.value;
        end
        if (ld) begin
            r_status <= ld_status;
            r_fpos   <= ld_fpos;
            r_elem   <= ld_elem;
            r_count  <= pole_pkg::CNT_W'(n_occ);
            r_last   <= ld_last;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < pole_pkg::CAPACITY; gi++) begin : g_cell
            logic signed [pole_pkg::VAL_W-1:0] left_in, right_in;
            if (gi == 0) begin : g_first
                assign left_in = tail;
            end else begin : g_inner_l
                assign left_in = c_data[gi-1];
            end
            if (gi == pole_pkg::CAPACITY - 1) begin : g_lastc
                assign right_in = head;
            end else begin : g_inner_r
                assign right_in = c_data[gi+1];
            end
            pole_cell u_cell (
                .i_clk   (i_clk),
                .i_index (pole_pkg::IDX_W'(gi)),
                .i_ctrl  (cell_ctrl),
                .i_left  (left_in),
                .i_right (right_in),
                .i_head  (head),
                .o_data  (c_data[gi]),
                .o_match (c_match[gi])
            );
        end
    endgenerate

    assign o_rsp.valid          = r_ov;
    assign o_rsp.status         = r_status;
    assign o_rsp.found_position = r_fpos;
    assign o_rsp.element        = r_elem;
    assign o_rsp.entry_count    = r_count;
    assign o_rsp.last_of_run    = r_last;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_occ) <= pole_pkg::CAPACITY)
        else $error("occupancy above capacity");

    a_mid_run_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_last) |-> (r_state == S_READ))
        else $error("non-final beat outside a read-out");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted request not executed next");

    a_occ_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ != $past(r_occ)) |-> ($past(r_state) == S_EXEC && $past(ld)))
        else $error("occupancy changed outside an executed request");

endmodule

// ===== rtl/pole_cell.sv =====
// One list cell: holds one entry and shifts or rotates with its neighbors.
module pole_cell (
    input  logic                                i_clk,
    input  logic [pole_pkg::IDX_W-1:0]          i_index,
    input  pole_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [pole_pkg::VAL_W-1:0]   i_left,
    input  logic signed [pole_pkg::VAL_W-1:0]   i_right,
    input  logic signed [pole_pkg::VAL_W-1:0]   i_head,
    output logic signed [pole_pkg::VAL_W-1:0]   o_data,
    output logic                                o_match
);

    logic signed [pole_pkg::VAL_W-1:0] r_data;
    logic signed [pole_pkg::VAL_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctrl.op)
            pole_pkg::CELL_HOLD: n_data = r_data;
            pole_pkg::CELL_INS: begin
                // open a gap at k: cells above take their left neighbor
                if (i_index > i_ctrl.k) begin
                    n_data = i_left;
                end else if (i_index == i_ctrl.k) begin
                    n_data = i_ctrl.value;
                end
            end
            pole_pkg::CELL_DEL: begin
                if (i_index >= i_ctrl.k) begin
                    n_data = i_right;
                end
            end
            // rotate within the occupied cells; the last one takes the head
            pole_pkg::CELL_ROTL: n_data = (i_index == i_ctrl.last) ? i_head : i_right;
            pole_pkg::CELL_ROTR: n_data = i_left;
            default:             n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_ctrl.value);

endmodule
